// ===== design/p2c_pkg.sv =====
// Package: widths, gain constant, arctangent table and pipeline vector type for polar_to_cartesian
`default_nettype none
package p2c_pkg;

	localparam int DATA_WIDTH   = 16;
	localparam int ITERATIONS   = 16;
	localparam int ATAN_ENTRIES = 24;
	localparam int NUM_CELLS    = (ITERATIONS < ATAN_ENTRIES) ? ITERATIONS : ATAN_ENTRIES;
	localparam int IDX_W        = $clog2(ATAN_ENTRIES);
	localparam int ANGLE_W      = 16;
	localparam int Z_W          = 32;
	// Q.31 vector plus CORDIC growth headroom
	localparam int XW           = 34;
	localparam int PROD_W       = DATA_WIDTH + 32;

	localparam logic signed [31:0] GAIN_Q31 = 32'sd1304065748;

	localparam logic [31:0] ATAN_TAB [ATAN_ENTRIES] = '{
		32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
		32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
		32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D, 32'h000028BE, 32'h0000145F,
		32'h00000A30, 32'h00000518, 32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
	};

	typedef struct packed {
		logic signed [XW-1:0]  x;
		logic signed [XW-1:0]  y;
		logic signed [Z_W-1:0] z;
		logic                  last;
	} p2c_vec_t;

endpackage
`default_nettype wire

// ===== design/p2c_front.sv =====
// Front end: gain multiply, quadrant split and pre-rotation, two pipeline stages
`default_nettype none
module p2c_front (
	input  wire logic                                   clk,
	input  wire logic                                   arst_n,
	input  wire logic                                   in_valid,
	output logic                                        in_ready,
	input  wire logic signed [p2c_pkg::DATA_WIDTH-1:0]  radius,
	input  wire logic        [p2c_pkg::ANGLE_W-1:0]     angle,
	input  wire logic                                   last_in,
	output logic                                        out_valid,
	input  wire logic                                   out_ready,
	output p2c_pkg::p2c_vec_t                           out_vec
);
	import p2c_pkg::*;

	logic signed [PROD_W-1:0]  prod;
	logic signed [PROD_W-1:0]  prod_s1;
	logic        [1:0]         quad;
	logic        [1:0]         quad_s1;
	logic        [ANGLE_W-1:0] zhi;
	logic        [ANGLE_W-1:0] zhi_s1;
	logic                      last_s1;
	logic                      valid_s1;
	logic                      ready_s1;
	logic signed [PROD_W-1:0]  prod_sh;
	logic signed [XW-1:0]      x0;
	p2c_vec_t                  vec;
	p2c_vec_t                  vec_s2;
	logic                      valid_s2;
	logic                      ready_s2;
	logic        [ANGLE_W-1:0] rnd_angle;

	assign prod      = PROD_W'(radius) * PROD_W'(GAIN_Q31);
	assign rnd_angle = angle + ANGLE_W'(16'h2000);
	assign quad      = rnd_angle[ANGLE_W-1 -: 2];
	assign zhi       = angle - {quad, {(ANGLE_W-2){1'b0}}};

	assign ready_s2 = !valid_s2 || out_ready;
	assign ready_s1 = !valid_s1 || ready_s2;
	assign in_ready = ready_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (ready_s1)
				valid_s1 <= in_valid;
			if (ready_s2)
				valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s1 && in_valid) begin
			prod_s1 <= prod;
			quad_s1 <= quad;
			zhi_s1  <= zhi;
			last_s1 <= last_in;
		end
		if (ready_s2 && valid_s1)
			vec_s2 <= vec;
	end

	assign prod_sh = prod_s1 >>> (DATA_WIDTH - 1);
	assign x0      = prod_sh[XW-1:0];

	always_comb begin
		vec.z    = $signed({zhi_s1, {(Z_W-ANGLE_W){1'b0}}});
		vec.last = last_s1;
		case (quad_s1)
			2'd0: begin
				vec.x = x0;
				vec.y = '0;
			end
			2'd1: begin
				vec.x = '0;
				vec.y = x0;
			end
			2'd2: begin
				vec.x = -x0;
				vec.y = '0;
			end
			default: begin
				vec.x = '0;
				vec.y = -x0;
			end
		endcase
	end

	assign out_valid = valid_s2;
	assign out_vec   = vec_s2;

endmodule
`default_nettype wire

// ===== design/p2c_cell.sv =====
// One CORDIC micro-rotation stage with its own pipeline register
`default_nettype none
module p2c_cell (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic [p2c_pkg::IDX_W-1:0]  index,
	input  wire logic                       in_valid,
	output logic                            in_ready,
	input  wire p2c_pkg::p2c_vec_t          in_vec,
	output logic                            out_valid,
	input  wire logic                       out_ready,
	output p2c_pkg::p2c_vec_t               out_vec
);
	import p2c_pkg::*;

	logic signed [XW-1:0]  xi;
	logic signed [XW-1:0]  yi;
	logic signed [XW-1:0]  xs;
	logic signed [XW-1:0]  ys;
	logic signed [Z_W-1:0] ang;
	p2c_vec_t              nxt;
	p2c_vec_t              vec_q;
	logic                  valid_q;

	assign xi  = in_vec.x;
	assign yi  = in_vec.y;
	assign xs  = xi >>> index;
	assign ys  = yi >>> index;
	assign ang = $signed(ATAN_TAB[index]);

	always_comb begin
		nxt.last = in_vec.last;
		if (!in_vec.z[Z_W-1]) begin
			nxt.x = xi - ys;
			nxt.y = yi + xs;
			nxt.z = in_vec.z - ang;
		end else begin
			nxt.x = xi + ys;
			nxt.y = yi - xs;
			nxt.z = in_vec.z + ang;
		end
	end

	assign in_ready = !valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_q <= 1'b0;
		else if (in_ready)
			valid_q <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid)
			vec_q <= nxt;
	end

	assign out_valid = valid_q;
	assign out_vec   = vec_q;

endmodule
`default_nettype wire

// ===== design/p2c_finish.sv =====
// Output stage: round to DATA_WIDTH, saturate and hold the result item
`default_nettype none
module p2c_finish (
	input  wire logic                                   clk,
	input  wire logic                                   arst_n,
	input  wire logic                                   in_valid,
	output logic                                        in_ready,
	input  wire p2c_pkg::p2c_vec_t                      in_vec,
	output logic                                        out_valid,
	input  wire logic                                   out_stall,
	output logic signed [p2c_pkg::DATA_WIDTH-1:0]       x_coord,
	output logic signed [p2c_pkg::DATA_WIDTH-1:0]       y_coord,
	output logic                                        last_out
);
	import p2c_pkg::*;

	localparam int SH = 32 - DATA_WIDTH;
	localparam logic signed [XW:0] RND = (SH > 0) ? (XW+1)'(1) <<< ((SH > 0) ? SH - 1 : 0)
	                                              : '0;
	localparam logic signed [XW:0] MAXV = (XW+1)'((64'sd1 <<< (DATA_WIDTH - 1)) - 1);
	localparam logic signed [XW:0] MINV = -MAXV - (XW+1)'(1);

	function automatic logic signed [DATA_WIDTH-1:0] sat_round(input logic signed [XW-1:0] w);
		logic signed [XW:0] v;
		begin
			v = ($signed({w[XW-1], w}) + RND) >>> SH;
			if (v > MAXV)
				sat_round = MAXV[DATA_WIDTH-1:0];
			else if (v < MINV)
				sat_round = MINV[DATA_WIDTH-1:0];
			else
				sat_round = v[DATA_WIDTH-1:0];
		end
	endfunction

	logic valid_q;

	assign in_ready = !valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_q <= 1'b0;
		else if (in_ready)
			valid_q <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			x_coord  <= sat_round(in_vec.x);
			y_coord  <= sat_round(in_vec.y);
			last_out <= in_vec.last;
		end
	end

	assign out_valid = valid_q;

endmodule
`default_nettype wire

// ===== design/polar_to_cartesian_unit.sv =====
// Top level: polar to Cartesian converter built as a pipelined CORDIC chain
// Converts (radius, angle) to x = radius*cos, y = radius*sin in Q1.15 with saturation. One item
// per clock while the output is not stalled; the pipeline is two front stages
// for the gain multiply and quadrant pre-rotation, one register per CORDIC cell, one output
// stage for rounding. Every stage holds its own item, so stalls at the output only back up as
// far as the pipeline is full and bubbles are squeezed out.
`default_nettype none
module polar_to_cartesian_unit (
	input  wire logic                                   clk,
	input  wire logic                                   arst_n,
	input  wire logic                                   in_valid,
	output logic                                        in_stall,
	input  wire logic signed [p2c_pkg::DATA_WIDTH-1:0]  radius,
	input  wire logic        [p2c_pkg::ANGLE_W-1:0]     angle,
	input  wire logic                                   last_in,
	output logic                                        out_valid,
	input  wire logic                                   out_stall,
	output logic signed [p2c_pkg::DATA_WIDTH-1:0]       x_coord,
	output logic signed [p2c_pkg::DATA_WIDTH-1:0]       y_coord,
	output logic                                        last_out
);
	import p2c_pkg::*;

	p2c_vec_t vec   [NUM_CELLS+1];
	logic     valid [NUM_CELLS+1];
	logic     ready [NUM_CELLS+1];
	logic     in_ready;

	assign in_stall = !in_ready;

	p2c_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.radius    (radius),
		.angle     (angle),
		.last_in   (last_in),
		.out_valid (valid[0]),
		.out_ready (ready[0]),
		.out_vec   (vec[0])
	);

	for (genvar k = 0; k < NUM_CELLS; k++) begin : g_cell
		p2c_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.index     (IDX_W'(k)),
			.in_valid  (valid[k]),
			.in_ready  (ready[k]),
			.in_vec    (vec[k]),
			.out_valid (valid[k+1]),
			.out_ready (ready[k+1]),
			.out_vec   (vec[k+1])
		);
	end

	p2c_finish u_finish (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (valid[NUM_CELLS]),
		.in_ready  (ready[NUM_CELLS]),
		.in_vec    (vec[NUM_CELLS]),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.x_coord   (x_coord),
		.y_coord   (y_coord),
		.last_out  (last_out)
	);

endmodule
`default_nettype wire

// ===== design/p2c_checker.sv =====
// Port-level checker for polar_to_cartesian_unit and its bind
`default_nettype none
module p2c_checker (
	input wire logic                                   clk,
	input wire logic                                   arst_n,
	input wire logic                                   in_valid,
	input wire logic                                   in_stall,
	input wire logic signed [p2c_pkg::DATA_WIDTH-1:0]  radius,
	input wire logic        [p2c_pkg::ANGLE_W-1:0]     angle,
	input wire logic                                   last_in,
	input wire logic                                   out_valid,
	input wire logic                                   out_stall,
	input wire logic signed [p2c_pkg::DATA_WIDTH-1:0]  x_coord,
	input wire logic signed [p2c_pkg::DATA_WIDTH-1:0]  y_coord,
	input wire logic                                   last_out
);

	// no result item during reset
	a_reset_quiet: assert property (@(posedge clk) !arst_n |-> !out_valid)
		else $error("out_valid high during reset");

	// input back-pressure only when the whole chain is full behind a stalled output
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (out_valid && out_stall))
		else $error("in_stall without a stalled result item");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> out_valid)
		else $error("result item dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=>
		($stable(x_coord) && $stable(y_coord) && $stable(last_out)))
		else $error("stalled result item changed");

endmodule

bind polar_to_cartesian_unit p2c_checker u_p2c_checker (.*);
`default_nettype wire

// ===== verif/polar_to_cartesian_unit_tb.sv =====
// Testbench for polar_to_cartesian_unit: random and corner polar pairs checked against a CORDIC model
`default_nettype none
module polar_to_cartesian_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int DW = p2c_pkg::DATA_WIDTH;
	localparam int ROT_STEPS = (p2c_pkg::ITERATIONS < 24) ? p2c_pkg::ITERATIONS : 24;
	localparam int OUT_SH = 32 - DW;
	localparam longint CORDIC_GAIN = 64'sd1304065748;
	localparam longint ATAN_STEP [24] = '{
		64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4, 64'h028B0D43, 64'h0145D7E1,
		64'h00A2F61E, 64'h00517C55, 64'h0028BE53, 64'h00145F2F, 64'h000A2F98, 64'h000517CC,
		64'h00028BE6, 64'h000145F3, 64'h0000A2FA, 64'h0000517D, 64'h000028BE, 64'h0000145F,
		64'h00000A30, 64'h00000518, 64'h0000028C, 64'h00000146, 64'h000000A3, 64'h00000051
	};
	localparam int RANDOM_ITEMS = 1130;
	localparam int DRAIN_CYCLES = p2c_pkg::NUM_CELLS + 3 + 16;

	typedef struct {
		logic signed [DW-1:0] radius;
		logic [p2c_pkg::ANGLE_W-1:0] angle;
		logic last;
	} polar_t;

	typedef struct {
		logic signed [DW-1:0] x;
		logic signed [DW-1:0] y;
		logic last;
	} cart_t;

	logic clk = 1'b0;
	logic arst_n = 1'b1;
	logic in_valid = 1'b0;
	logic in_stall;
	logic signed [DW-1:0] radius = '0;
	logic [p2c_pkg::ANGLE_W-1:0] angle = '0;
	logic last_in = 1'b0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic signed [DW-1:0] x_coord;
	logic signed [DW-1:0] y_coord;
	logic last_out;

	polar_t polar_backlog[$];
	cart_t cart_due[$];
	polar_t next_polar;
	cart_t got_cart;
	int items_taken = 0;
	int plan_total = 1;
	int send_idle_pct;
	int recv_stall_pct;
	int fails = 0;

	polar_to_cartesian_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.radius(radius),
		.angle(angle),
		.last_in(last_in),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.x_coord(x_coord),
		.y_coord(y_coord),
		.last_out(last_out)
	);

	always #10 clk = ~clk;

	function automatic logic signed [DW-1:0] round_sat(longint w);
		longint v;
		longint maxv;
		longint minv;
		maxv = (64'sd1 <<< (DW - 1)) - 1;
		minv = -maxv - 1;
		v = w;
		if (OUT_SH > 0)
			v = (w + (64'sd1 <<< (OUT_SH - 1))) >>> OUT_SH;
		if (v > maxv)
			v = maxv;
		if (v < minv)
			v = minv;
		return v[DW-1:0];
	endfunction

	function automatic cart_t polar_to_cart(polar_t p);
		longint x0;
		longint x;
		longint y;
		longint z;
		longint xs;
		longint ys;
		logic [31:0] ph;
		logic [31:0] q;
		cart_t res;
		x0 = (longint'(p.radius) * CORDIC_GAIN) >>> (DW - 1);
		ph = {p.angle, 16'h0000};
		q = (ph + 32'h2000_0000) >> 30;
		z = longint'({32'h0, ph}) - longint'({32'h0, q}) * 64'sd1073741824;
		if (z >= 64'sd2147483648)
			z = z - 64'sd4294967296;
		case (q)
			32'd0: begin x = x0; y = 0; end
			32'd1: begin x = 0; y = x0; end
			32'd2: begin x = -x0; y = 0; end
			default: begin x = 0; y = -x0; end
		endcase
		for (int i = 0; i < ROT_STEPS; i++) begin
			ys = y >>> i;
			xs = x >>> i;
			if (z >= 0) begin
				x = x - ys;
				y = y + xs;
				z = z - ATAN_STEP[i];
			end else begin
				x = x + ys;
				y = y - xs;
				z = z + ATAN_STEP[i];
			end
		end
		res.x = round_sat(x);
		res.y = round_sat(y);
		res.last = p.last;
		return res;
	endfunction

	task automatic add_polar(int r, int a, bit l);
		polar_t p;
		p.radius = r[DW-1:0];
		p.angle = a[p2c_pkg::ANGLE_W-1:0];
		p.last = l;
		polar_backlog.push_back(p);
	endtask

	function automatic int pick_radius();
		case ($urandom_range(5))
			0: return -32768;
			1: return -32767;
			2: return -1;
			3: return 0;
			4: return 1;
			default: return 32767;
		endcase
	endfunction

	always_comb begin
		if (items_taken < plan_total / 3) begin
			send_idle_pct = 17;
			recv_stall_pct = 45;
		end else if (items_taken < (2 * plan_total) / 3) begin
			send_idle_pct = 45;
			recv_stall_pct = 17;
		end else begin
			send_idle_pct = 0;
			recv_stall_pct = 0;
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			radius <= '0;
			angle <= '0;
			last_in <= 1'b0;
		end else begin
			if (in_valid && !in_stall) begin
				next_polar.radius = radius;
				next_polar.angle = angle;
				next_polar.last = last_in;
				cart_due.push_back(polar_to_cart(next_polar));
				items_taken <= items_taken + 1;
			end
			if (!in_valid || !in_stall) begin
				if (polar_backlog.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
					next_polar = polar_backlog.pop_front();
					in_valid <= 1'b1;
					radius <= next_polar.radius;
					angle <= next_polar.angle;
					last_in <= next_polar.last;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				if (cart_due.size() == 0) begin
					$error("unexpected item: x_coord=%0d y_coord=%0d last_out=%0b",
						x_coord, y_coord, last_out);
					fails++;
				end else begin
					got_cart = cart_due.pop_front();
					if (x_coord !== got_cart.x) begin
						$error("x_coord: expected %0d, actual %0d", got_cart.x, x_coord);
						fails++;
					end
					if (y_coord !== got_cart.y) begin
						$error("y_coord: expected %0d, actual %0d", got_cart.y, y_coord);
						fails++;
					end
					if (last_out !== got_cart.last) begin
						$error("last_out: expected %0b, actual %0b", got_cart.last, last_out);
						fails++;
					end
				end
			end
			out_stall <= ($urandom_range(99) < recv_stall_pct);
		end
	end

	initial begin
		int r;
		int a;
		arst_n <= 1'b0;
		// axes, both radius extremes, quadrant boundaries and wrap near a full turn
		add_polar(32767, 0, 0);
		add_polar(32767, 16384, 0);
		add_polar(32767, 32768, 1);
		add_polar(32767, 49152, 0);
		add_polar(-32768, 0, 0);
		add_polar(-32768, 16384, 0);
		// minus one at a half turn saturates to the top code
		add_polar(-32768, 32768, 1);
		add_polar(-32768, 49152, 0);
		add_polar(0, 12345, 0);
		add_polar(1, 0, 1);
		add_polar(-1, 0, 0);
		add_polar(-1, 40000, 0);
		add_polar(32767, 8191, 0);
		add_polar(32767, 8192, 0);
		add_polar(-32768, 24575, 1);
		add_polar(-32768, 24576, 0);
		add_polar(32767, 40960, 0);
		add_polar(32767, 57343, 0);
		add_polar(32767, 57344, 1);
		add_polar(32767, 65535, 0);
		add_polar(-32768, 65535, 1);
		add_polar(16384, 5461, 0);
		add_polar(-16384, 27307, 1);
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if ($urandom_range(4) == 0)
				r = pick_radius();
			else
				r = $urandom;
			case ($urandom_range(9))
				0, 1: a = $urandom_range(3) * 16384 + 8192 + $urandom_range(6) - 3;
				2: a = $urandom_range(3) * 16384 + $urandom_range(6) - 3;
				default: a = $urandom;
			endcase
			add_polar(r, a, $urandom_range(7) == 0);
		end
		plan_total = polar_backlog.size();

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		while (items_taken < plan_total)
			@(posedge clk);
		while (cart_due.size() > 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (cart_due.size() != 0) begin
			$error("%0d expected items never arrived", cart_due.size());
			fails++;
		end
		if (fails == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

	initial begin
		#2_000_000;
		$display("simulation failed");
		$finish;
	end

endmodule
`default_nettype wire

// ===== polar_to_cartesian_unit.f =====
design/p2c_pkg.sv
design/p2c_front.sv
design/p2c_cell.sv
design/p2c_finish.sv
design/polar_to_cartesian_unit.sv
design/p2c_checker.sv
verif/polar_to_cartesian_unit_tb.sv
